// ===== rtl/core/eir_pkg.sv =====
package eir_pkg;

    // Default geometry of the root search
    localparam int RADICAND_BITS_DEF = 31;
    localparam int MAX_EXPONENT_DEF  = 64;

    // Fixed width of the exponent field
    localparam int EXPONENT_BITS = 7;

    // Operand slice width of the shared multiplier
    localparam int MUL_CHUNK = 32;

endpackage

// ===== rtl/core/exact_integer_nth_root.sv =====
// Exact integer nth root by binary search over 1..radicand.
//
// Input channel (in_valid/in_ready) carries radicand and exponent; an
// exponent above MAX_EXPONENT saturates to it. Output channel
// (out_valid/out_ready) returns found and root; root is 0 when no exact
// root exists, and a zero radicand always gives found = 0.
//
// One request is worked at a time: in_ready is high only while the search
// sequencer is idle. Each candidate raises its power by repeated
// multiplication, and each multiplication forms C*C partial products on the
// shared multiplier, where C = ceil(RADICAND_BITS / 32) is the number of
// operand slices. A power stops once the partial product exceeds the
// radicand, and the search visits at most RADICAND_BITS candidates.
//
// The result sits in an output register; a stalled receiver holds it while
// the next request is accepted and searched. A finished search waits only
// if the previous result has not been taken. Reset clears all control
// state and drops any pending result.
module exact_integer_nth_root
    import eir_pkg::*;
#(
    parameter int RADICAND_BITS = RADICAND_BITS_DEF,
    parameter int MAX_EXPONENT  = MAX_EXPONENT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [RADICAND_BITS-1:0]  radicand,
    input  logic [EXPONENT_BITS-1:0]  exponent,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [RADICAND_BITS-1:0]  root
);

    localparam int RB = RADICAND_BITS;
    localparam int NW = $clog2(MAX_EXPONENT + 1);
    localparam int OW = 2 * RADICAND_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_POW  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    state_reg,     state_next;
    logic [RB:0]   lo_reg,        lo_next;
    logic [RB-1:0] hi_reg,        hi_next;
    logic [RB-1:0] m_reg,         m_next;
    logic [NW-1:0] n_reg,         n_next;
    logic [RB-1:0] mid_reg,       mid_next;
    logic [RB-1:0] acc_reg,       acc_next;
    logic [NW-1:0] cnt_reg,       cnt_next;
    logic          hit_reg,       hit_next;
    logic          out_valid_reg, out_valid_next;
    logic          found_reg,     found_next;
    logic [RB-1:0] root_reg,      root_next;

    logic [RB+1:0] mid_sum;
    logic          mul_start;
    logic          mul_done;
    logic [OW-1:0] mul_prod;
    logic          out_free;

    // Shared multiplier: partial power times candidate
    eir_mul #(
        .RADICAND_BITS (RADICAND_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (acc_reg),
        .b     (mid_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign mid_sum   = {1'b0, lo_reg} + {2'b00, hi_reg};
    assign mul_start = (state_reg == S_POW) && (cnt_reg != n_reg);
    assign out_free  = !out_valid_reg || out_ready;

    // Advance the search sequencer
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        mid_next       = mid_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        root_next      = root_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    m_next  = radicand;
                    lo_next = (RB+1)'(1);
                    hi_next = radicand;
                    if ({1'b0, exponent} > (EXPONENT_BITS+1)'(MAX_EXPONENT))
                    begin
                        n_next = NW'(MAX_EXPONENT);
                    end
                    else
                    begin
                        n_next = NW'(exponent);
                    end
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg > {1'b0, hi_reg})
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next   = mid_sum[RB:1];
                    acc_next   = RB'(1);
                    cnt_next   = '0;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    if (mul_prod > OW'(m_reg))
                    begin
                        hi_next    = mid_reg - RB'(1);
                        state_next = S_SRCH;
                    end
                    else
                    begin
                        acc_next   = mul_prod[RB-1:0];
                        cnt_next   = cnt_reg + NW'(1);
                        state_next = S_POW;
                    end
                end
            end
            S_CMP:
            begin
                if (acc_reg == m_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    lo_next    = {1'b0, mid_reg} + (RB+1)'(1);
                    state_next = S_SRCH;
                end
            end
            S_DONE:
            begin
                // Load the result only once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    root_next      = hit_reg ? mid_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Update control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
        end
    end

    // Update search operands and the result register
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        m_reg     <= m_next;
        mid_reg   <= mid_next;
        acc_reg   <= acc_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        root_reg  <= root_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign root      = root_reg;

    // A missing root is reported as zero
    a_root_zero_when_missing: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> root == '0
    ) else $error("root not zero on a missing root");

    // A found root is never zero
    a_root_nonzero_when_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && found |-> root != '0
    ) else $error("found root is zero");

    // The multiplier finishes only while the sequencer waits for it
    a_mul_done_in_wait: assert property (
        @(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_WAIT
    ) else $error("multiplier finished outside the wait state");

    // The power count never passes the exponent
    a_cnt_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_POW || state_reg == S_WAIT || state_reg == S_CMP)
            |-> cnt_reg <= n_reg
    ) else $error("power count passed the exponent");

    // A search result is registered only when the output was free
    a_done_needs_free_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid && !out_ready |=> state_reg == S_DONE
    ) else $error("result dropped over a stalled one");

endmodule

// ===== rtl/core/eir_mul.sv =====
module eir_mul
    import eir_pkg::*;
#(
    parameter int RADICAND_BITS = RADICAND_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [RADICAND_BITS-1:0]     a,
    input  logic [RADICAND_BITS-1:0]     b,
    output logic                         done,
    output logic [2*RADICAND_BITS-1:0]   prod
);

    localparam int NCH = (RADICAND_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int EW  = NCH * MUL_CHUNK;
    localparam int PW  = 2 * EW;
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int OW  = 2 * RADICAND_BITS;

    localparam logic PH_MUL = 1'b0;
    localparam logic PH_ADD = 1'b1;

    localparam logic [IW-1:0] LAST_IDX = IW'(NCH - 1);

    logic                   busy_reg;
    logic                   phase_reg;
    logic [IW-1:0]          ia_reg;
    logic [IW-1:0]          ib_reg;
    logic                   done_reg;
    logic [EW-1:0]          a_reg;
    logic [EW-1:0]          b_reg;
    logic [2*MUL_CHUNK-1:0] pp_reg;
    logic [PW-1:0]          acc_reg;

    logic [MUL_CHUNK-1:0]   a_slice;
    logic [MUL_CHUNK-1:0]   b_slice;
    logic [PW-1:0]          pp_shifted;
    logic                   last_pp;

    // Select the operand slices of the current partial product
    assign a_slice    = a_reg[ia_reg*MUL_CHUNK +: MUL_CHUNK];
    assign b_slice    = b_reg[ib_reg*MUL_CHUNK +: MUL_CHUNK];
    assign pp_shifted = PW'(pp_reg) << (MUL_CHUNK * (int'(ia_reg) + int'(ib_reg)));
    assign last_pp    = (ia_reg == LAST_IDX) && (ib_reg == LAST_IDX);

    // Sequence the partial products: multiply, then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_MUL;
            ia_reg    <= '0;
            ib_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= PH_MUL;
                    ia_reg    <= '0;
                    ib_reg    <= '0;
                end
            end
            else if (phase_reg == PH_MUL)
            begin
                phase_reg <= PH_ADD;
            end
            else
            begin
                phase_reg <= PH_MUL;
                if (last_pp)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else if (ib_reg == LAST_IDX)
                begin
                    ib_reg <= '0;
                    ia_reg <= ia_reg + 1'b1;
                end
                else
                begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
        end
    end

    // Hold operands and accumulate the product
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (start)
            begin
                a_reg   <= EW'(a);
                b_reg   <= EW'(b);
                acc_reg <= '0;
            end
        end
        else if (phase_reg == PH_MUL)
        begin
            pp_reg <= a_slice * b_slice;
        end
        else
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[OW-1:0];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

localparam int RAD_W = eir_pkg::RADICAND_BITS_DEF;
localparam int EXP_W = eir_pkg::EXPONENT_BITS;
localparam int EXP_CAP = eir_pkg::MAX_EXPONENT_DEF;

typedef struct packed
{
    logic             found;
    logic [RAD_W-1:0] root;
} root_result_t;

typedef enum {POW_BELOW, POW_EQUAL, POW_ABOVE} pow_cmp_t;

class root_tracker;
    root_result_t expected_roots[$];
    int           failures;

    function new();
        failures = 0;
    endfunction

    // Compare cand^n with target, stopping once the partial product is too big
    function pow_cmp_t compare_power(longint unsigned cand, longint unsigned n,
                                     longint unsigned target);
        longint unsigned acc;
        longint unsigned lim;
        acc = 1;
        lim = target / cand;
        for (longint unsigned i = 0; i < n; i++)
        begin
            if (acc > lim)
                return POW_ABOVE;
            acc = acc * cand;
        end
        if (acc == target)
            return POW_EQUAL;
        return (acc < target) ? POW_BELOW : POW_ABOVE;
    endfunction

    // Binary search for an exact root over 1..radicand
    function root_result_t search_root(logic [RAD_W-1:0] rad, logic [EXP_W-1:0] expo);
        longint unsigned m;
        longint unsigned n;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        pow_cmp_t        cmp;
        root_result_t    res;
        m = rad;
        n = expo;
        if (n > EXP_CAP)
            n = EXP_CAP;
        lo = 1;
        hi = m;
        res = '0;
        while (lo <= hi && !res.found)
        begin
            mid = lo + ((hi - lo) >> 1);
            cmp = compare_power(mid, n, m);
            if (cmp == POW_EQUAL)
            begin
                res.found = 1'b1;
                res.root  = mid[RAD_W-1:0];
            end
            else if (cmp == POW_BELOW)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return res;
    endfunction

    function void note_request(logic [RAD_W-1:0] rad, logic [EXP_W-1:0] expo);
        expected_roots.push_back(search_root(rad, expo));
    endfunction

    function void report(string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    function void check_result(logic got_found, logic [RAD_W-1:0] got_root);
        root_result_t want;
        if (expected_roots.size() == 0)
        begin
            report($sformatf("unexpected result found=%0b root=%0d", got_found, got_root));
            return;
        end
        want = expected_roots.pop_front();
        if (got_found !== want.found || got_root !== want.root)
            report($sformatf("mismatch: expected found=%0b root=%0d, got found=%0b root=%0d",
                             want.found, want.root, got_found, got_root));
    endfunction

    function int pending();
        return expected_roots.size();
    endfunction

    // Count results that never showed up
    function void close();
        if (expected_roots.size() != 0)
            report($sformatf("%0d results never arrived", expected_roots.size()));
    endfunction
endclass

module tb_top;

    localparam int RANDOM_REQUESTS = 430;
    localparam int CYCLE_LIMIT     = 16_000_000;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 6000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [RAD_W-1:0] radicand = '0;
    logic [EXP_W-1:0] exponent = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             found;
    logic [RAD_W-1:0] root;

    logic             hold_off = 1'b0;
    int               accepted = 0;
    int               burst_left = 0;
    longint           cycles = 0;
    root_tracker      tracker = new();

    exact_integer_nth_root uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .radicand  (radicand),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .root      (root)
    );

    always #6 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive out_ready: always-ready stretches mixed with short toggling runs
    always @(posedge clk)
    begin
        int  run_left;
        bit  run_val;
        if (hold_off)
            out_ready <= 1'b0;
        else
        begin
            if (run_left <= 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    run_val  = 1'b1;
                    run_left = $urandom_range(50, 300);
                end
                else
                begin
                    run_val  = $urandom_range(0, 2) != 0;
                    run_left = $urandom_range(1, 8);
                end
            end
            else
                run_left--;
            out_ready <= run_val;
        end
    end

    // Check every result the receiver takes
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(found, root);
    end

    // Hold the receiver off for a long stretch so the block backs up
    initial
    begin
        wait (accepted >= HOLD_OFF_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one request and wait until it is taken, then maybe idle
    task automatic send_request(input logic [RAD_W-1:0] r, input logic [EXP_W-1:0] e);
        int gap;
        in_valid <= 1'b1;
        radicand <= r;
        exponent <= e;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(r, e);
        accepted++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Build a perfect power with a random base and degree
    task automatic make_power(output logic [RAD_W-1:0] r, output logic [EXP_W-1:0] e);
        int              n;
        longint unsigned base;
        longint unsigned bmax;
        longint unsigned p;
        n = $urandom_range(1, 30);
        if (n == 1)
        begin
            r = RAD_W'($urandom());
            e = EXP_W'(1);
            return;
        end
        bmax = (64'd1 << (31 / n)) - 1;
        if (bmax < 2)
            bmax = 2;
        base = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, bmax);
        p = 1;
        repeat (n) p = p * base;
        r = p[RAD_W-1:0];
        e = EXP_W'(n);
    endtask

    task automatic make_random_request(output logic [RAD_W-1:0] r, output logic [EXP_W-1:0] e);
        int sel;
        int w;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            make_power(r, e);
        else if (sel < 65)
        begin
            // Near miss: one off a perfect power
            make_power(r, e);
            if ($urandom_range(0, 1) == 1 || r < 2)
                r = r + RAD_W'(1);
            else
                r = r - RAD_W'(1);
        end
        else
        begin
            w = $urandom_range(0, RAD_W);
            r = RAD_W'($urandom() & ((64'd1 << w) - 1));
            e = EXP_W'($urandom_range(0, 127));
        end
    endtask

    initial
    begin
        logic [RAD_W-1:0] r;
        logic [EXP_W-1:0] e;
        int               settle;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero radicand, zero and oversize exponent
        send_request(31'd0, 7'd1);
        send_request(31'd0, 7'd0);
        send_request(31'd0, 7'd127);
        send_request(31'd1, 7'd0);
        send_request(31'd5, 7'd0);
        send_request(31'd1, 7'd1);
        send_request(31'd1, 7'd64);
        send_request(31'd1, 7'd127);
        send_request(31'd2, 7'd1);
        send_request(31'h7FFF_FFFF, 7'd1);
        send_request(31'h7FFF_FFFF, 7'd2);
        send_request(31'h7FFF_FFFF, 7'd64);
        send_request(31'h7FFF_FFFF, 7'd127);
        send_request(31'h7FFF_FFFF, 7'd0);
        send_request(31'd2147395600, 7'd2);
        send_request(31'd2146689000, 7'd3);
        send_request(31'd1162261467, 7'd19);
        send_request(31'd1977326743, 7'd11);
        send_request(31'h4000_0000, 7'd30);
        send_request(31'h4000_0000, 7'd31);
        send_request(31'h4000_0000, 7'd65);
        send_request(31'd100, 7'd3);
        send_request(31'd81, 7'd4);

        // Random: half perfect powers, some near misses, the rest noise
        repeat (RANDOM_REQUESTS)
        begin
            make_random_request(r, e);
            send_request(r, e);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        tracker.close();
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/eir_pkg.sv
rtl/core/eir_mul.sv
rtl/core/exact_integer_nth_root.sv
sim/tb_top.sv
